### design/eit_pkg.sv
package eit_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_EVENT  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  localparam int LengthPos   = 2;
  localparam int HeaderLast  = 13;
  localparam int LoopFirst   = 14;
  localparam int EventBytes  = 12;
  localparam int CrcBytes    = 4;
  localparam int MinTotal    = 15;
  localparam int TotalExtra  = 3;
  localparam int TotalW      = 13;
  localparam int EvIdxW      = 4;
  localparam int SkipW       = 12;
  localparam int EvCountW    = 9;

endpackage

### design/eit_section_parser_top.sv
// channel | handshake          | payload
// --------+--------------------+------------------------------------------------
// in      | in_valid/in_ready  | in_byte_value, in_section_start
// out     | out_valid/out_ready| out_record_kind and the eleven record fields
//
// One section byte is taken every cycle; its record, if any, shows in the next cycle.
// The rate is set by the single output register: a byte is refused only while a
// record sits in it and out_ready is low.
// rst_n is synchronous and active low; it idles the parser and empties the output.
// A stalled output holds its record unchanged until taken.
module eit_section_parser_top #(
  parameter int MAX_SECTION_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_section_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [7:0]  out_table_ident,
  output logic [11:0] out_length_of_section,
  output logic [15:0] out_service_ident,
  output logic [4:0]  out_version_value,
  output logic [1:0]  out_indicator_flags,
  output logic [15:0] out_section_numbers,
  output logic [31:0] out_network_idents,
  output logic [15:0] out_segment_info,
  output logic [15:0] out_event_ident,
  output logic [39:0] out_time_or_check,
  output logic [39:0] out_event_info
);

  localparam int PosW = $clog2(MAX_SECTION_BYTES);
  localparam int TW   = eit_pkg::TotalW;
  localparam logic [TW-1:0] MaxTotal = TW'(MAX_SECTION_BYTES);

  logic                          active_r, active_nxt;
  logic [PosW-1:0]               pos_r, pos_nxt, pos_cur;
  logic [TW-1:0]                 total_r, total_nxt;
  logic [103:0]                  hdr_r, hdr_nxt;
  logic [87:0]                   ev_r, ev_nxt;
  logic [eit_pkg::EvIdxW-1:0]    idx_r, idx_nxt, idx_cur;
  logic [eit_pkg::SkipW-1:0]     skip_r, skip_nxt, skip_cur;
  logic [eit_pkg::EvCountW-1:0]  found_r, found_nxt, found_cur;
  logic [31:0]                   crc_r, crc_nxt;
  logic [TW-1:0]                 pos_ext;
  logic                          accept;
  logic                          emit;

  eit_pkg::kind_t kind_r, kind_nxt;
  logic        out_valid_r;
  logic [7:0]  table_r, table_nxt;
  logic [11:0] length_r, length_nxt;
  logic [15:0] service_r, service_nxt;
  logic [4:0]  version_r, version_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [15:0] secnum_r, secnum_nxt;
  logic [31:0] network_r, network_nxt;
  logic [15:0] segment_r, segment_nxt;
  logic [15:0] event_r, event_nxt;
  logic [39:0] time_r, time_nxt;
  logic [39:0] info_r, info_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_cur   = in_section_start ? '0 : pos_r;
  assign idx_cur   = in_section_start ? '0 : idx_r;
  assign skip_cur  = in_section_start ? '0 : skip_r;
  assign found_cur = in_section_start ? '0 : found_r;
  assign pos_ext   = TW'(pos_cur);

  always_comb begin
    active_nxt  = active_r || in_section_start;
    pos_nxt     = pos_cur;
    total_nxt   = total_r;
    hdr_nxt     = hdr_r;
    ev_nxt      = ev_r;
    idx_nxt     = idx_cur;
    skip_nxt    = skip_cur;
    found_nxt   = found_cur;
    crc_nxt     = (in_section_start ? 32'd0 : crc_r);
    emit        = 1'b0;
    kind_nxt    = eit_pkg::KIND_HEADER;
    table_nxt   = '0;
    length_nxt  = '0;
    service_nxt = '0;
    version_nxt = '0;
    flags_nxt   = '0;
    secnum_nxt  = '0;
    network_nxt = '0;
    segment_nxt = '0;
    event_nxt   = '0;
    time_nxt    = '0;
    info_nxt    = '0;
    if (active_nxt) begin
      crc_nxt = {crc_nxt[23:0], in_byte_value};
      pos_nxt = pos_cur + PosW'(1);
      if (pos_cur < PosW'(eit_pkg::HeaderLast)) begin
        hdr_nxt = {hdr_r[95:0], in_byte_value};
      end
      if (pos_cur == PosW'(eit_pkg::LengthPos)) begin
        total_nxt = TW'({hdr_r[3:0], in_byte_value}) + TW'(eit_pkg::TotalExtra);
        if (total_nxt < TW'(eit_pkg::MinTotal) || total_nxt > MaxTotal) begin
          active_nxt = 1'b0;
        end
      end
      if (pos_cur == PosW'(eit_pkg::HeaderLast)) begin
        emit        = 1'b1;
        kind_nxt    = eit_pkg::KIND_HEADER;
        table_nxt   = hdr_r[103:96];
        length_nxt  = {hdr_r[91:88], hdr_r[87:80]};
        service_nxt = hdr_r[79:64];
        version_nxt = hdr_r[61:57];
        flags_nxt   = {hdr_r[95], hdr_r[56]};
        secnum_nxt  = hdr_r[55:40];
        network_nxt = hdr_r[39:8];
        segment_nxt = {hdr_r[7:0], in_byte_value};
      end else if (pos_cur >= PosW'(eit_pkg::LoopFirst) &&
                   pos_ext + TW'(eit_pkg::CrcBytes) < total_r) begin
        if (skip_cur != '0) begin
          skip_nxt = skip_cur - eit_pkg::SkipW'(1);
        end else begin
          ev_nxt  = {ev_r[79:0], in_byte_value};
          idx_nxt = idx_cur + eit_pkg::EvIdxW'(1);
          if (idx_nxt >= eit_pkg::EvIdxW'(eit_pkg::EventBytes)) begin
            emit      = 1'b1;
            kind_nxt  = eit_pkg::KIND_EVENT;
            event_nxt = ev_r[87:72];
            time_nxt  = ev_r[71:32];
            info_nxt  = {ev_r[31:0], in_byte_value};
            idx_nxt   = '0;
            skip_nxt  = {ev_r[3:0], in_byte_value};
            found_nxt = found_cur + eit_pkg::EvCountW'(1);
          end
        end
      end else if (pos_cur > PosW'(eit_pkg::HeaderLast) &&
                   pos_ext + TW'(1) == total_r) begin
        emit       = 1'b1;
        kind_nxt   = eit_pkg::KIND_END;
        event_nxt  = 16'(found_cur);
        time_nxt   = {8'd0, crc_nxt};
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
      skip_r      <= '0;
      found_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        active_r    <= active_nxt;
        pos_r       <= pos_nxt;
        idx_r       <= idx_nxt;
        skip_r      <= skip_nxt;
        found_r     <= found_nxt;
        total_r     <= total_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r <= hdr_nxt;
      ev_r  <= ev_nxt;
      crc_r <= crc_nxt;
      if (emit) begin
        kind_r    <= kind_nxt;
        table_r   <= table_nxt;
        length_r  <= length_nxt;
        service_r <= service_nxt;
        version_r <= version_nxt;
        flags_r   <= flags_nxt;
        secnum_r  <= secnum_nxt;
        network_r <= network_nxt;
        segment_r <= segment_nxt;
        event_r   <= event_nxt;
        time_r    <= time_nxt;
        info_r    <= info_nxt;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_record_kind       = kind_r;
  assign out_table_ident       = table_r;
  assign out_length_of_section = length_r;
  assign out_service_ident     = service_r;
  assign out_version_value     = version_r;
  assign out_indicator_flags   = flags_r;
  assign out_section_numbers   = secnum_r;
  assign out_network_idents    = network_r;
  assign out_segment_info      = segment_r;
  assign out_event_ident       = event_r;
  assign out_time_or_check     = time_r;
  assign out_event_info        = info_r;

`ifndef ASSERT_OFF
  a_start_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_section_start |=> !out_valid_r)
    else $error("record emitted on a section start byte");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == eit_pkg::KIND_HEADER |->
      event_r == '0 && time_r == '0 && info_r == '0)
    else $error("header record carries event fields");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < eit_pkg::EvIdxW'(eit_pkg::EventBytes))
    else $error("event byte index out of range");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == eit_pkg::KIND_END |-> !active_r)
    else $error("parser still active behind an end record");
`endif

endmodule

### bench/tb_eit_section_parser_top.sv
`timescale 1ns / 1ps

module tb_eit_section_parser_top;

  localparam int MaxSectionBytes = 4096;
  localparam int StallLimit = 2000;
  localparam int LongHold = 300;

  typedef struct packed {
    eit_pkg::kind_t kind;
    logic [7:0]  table_ident;
    logic [11:0] length_of_section;
    logic [15:0] service_ident;
    logic [4:0]  version_value;
    logic [1:0]  indicator_flags;
    logic [15:0] section_numbers;
    logic [31:0] network_idents;
    logic [15:0] segment_info;
    logic [15:0] event_ident;
    logic [39:0] time_or_check;
    logic [39:0] event_info;
  } eit_record_t;

  class eit_record_tracker;
    eit_record_t pending_records[$];
    int mismatches;
    logic [11:0] pos;
    logic [eit_pkg::TotalW-1:0] total;
    bit active;
    logic [111:0] hdr_bytes;
    logic [eit_pkg::EvIdxW-1:0] ev_idx;
    logic [95:0] ev_bytes;
    logic [eit_pkg::SkipW-1:0] skip_left;
    logic [eit_pkg::EvCountW-1:0] found;
    logic [31:0] crc_bytes;

    function new();
      mismatches = 0;
      clear();
      active = 0;
    endfunction

    function void clear();
      pos = '0;
      total = '0;
      hdr_bytes = '0;
      ev_idx = '0;
      ev_bytes = '0;
      skip_left = '0;
      found = '0;
      crc_bytes = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic start);
      eit_record_t r;
      bit emit;
      r = '0;
      emit = 0;
      if (start) begin
        clear();
        active = 1;
      end
      if (!active) return;
      crc_bytes = {crc_bytes[23:0], b};
      if (pos <= eit_pkg::HeaderLast) hdr_bytes = {hdr_bytes[103:0], b};
      if (pos == eit_pkg::LengthPos) begin
        total = eit_pkg::TotalW'({1'b0, hdr_bytes[11:8], b} + eit_pkg::TotalExtra);
        if (total < eit_pkg::MinTotal || total > MaxSectionBytes) begin
          active = 0;
          return;
        end
      end
      if (pos == eit_pkg::HeaderLast) begin
        r.kind = eit_pkg::KIND_HEADER;
        r.table_ident = hdr_bytes[111:104];
        r.length_of_section = hdr_bytes[99:88];
        r.service_ident = hdr_bytes[87:72];
        r.version_value = hdr_bytes[69:65];
        r.indicator_flags = {hdr_bytes[103], hdr_bytes[64]};
        r.section_numbers = hdr_bytes[63:48];
        r.network_idents = hdr_bytes[47:16];
        r.segment_info = hdr_bytes[15:0];
        emit = 1;
      end else if (pos >= eit_pkg::LoopFirst && pos + eit_pkg::CrcBytes < total) begin
        if (skip_left != 0) begin
          skip_left--;
        end else begin
          ev_bytes = {ev_bytes[87:0], b};
          ev_idx++;
          if (ev_idx >= eit_pkg::EventBytes) begin
            r.kind = eit_pkg::KIND_EVENT;
            r.event_ident = ev_bytes[95:80];
            r.time_or_check = ev_bytes[79:40];
            r.event_info = ev_bytes[39:0];
            emit = 1;
            ev_idx = '0;
            skip_left = ev_bytes[11:0];
            found++;
          end
        end
      end else if (pos > eit_pkg::HeaderLast && pos + 1 == total) begin
        r.kind = eit_pkg::KIND_END;
        r.event_ident = {7'b0, found};
        r.time_or_check = {8'b0, crc_bytes};
        emit = 1;
        active = 0;
      end
      pos++;
      if (emit) pending_records.push_back(r);
    endfunction

    function void check_field(string name, logic [39:0] want, logic [39:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_record(eit_record_t got);
      eit_record_t want;
      if (pending_records.size() == 0) begin
        $display("%0t unexpected record: expected none actual kind %0d", $time, got.kind);
        mismatches++;
        return;
      end
      want = pending_records.pop_front();
      check_field("record_kind", 40'(want.kind), 40'(got.kind));
      check_field("table_ident", 40'(want.table_ident), 40'(got.table_ident));
      check_field("length_of_section", 40'(want.length_of_section),
                  40'(got.length_of_section));
      check_field("service_ident", 40'(want.service_ident), 40'(got.service_ident));
      check_field("version_value", 40'(want.version_value), 40'(got.version_value));
      check_field("indicator_flags", 40'(want.indicator_flags), 40'(got.indicator_flags));
      check_field("section_numbers", 40'(want.section_numbers), 40'(got.section_numbers));
      check_field("network_idents", 40'(want.network_idents), 40'(got.network_idents));
      check_field("segment_info", 40'(want.segment_info), 40'(got.segment_info));
      check_field("event_ident", 40'(want.event_ident), 40'(got.event_ident));
      check_field("time_or_check", want.time_or_check, got.time_or_check);
      check_field("event_info", want.event_info, got.event_info);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_section_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_record_kind;
  logic [7:0]  out_table_ident;
  logic [11:0] out_length_of_section;
  logic [15:0] out_service_ident;
  logic [4:0]  out_version_value;
  logic [1:0]  out_indicator_flags;
  logic [15:0] out_section_numbers;
  logic [31:0] out_network_idents;
  logic [15:0] out_segment_info;
  logic [15:0] out_event_ident;
  logic [39:0] out_time_or_check;
  logic [39:0] out_event_info;

  eit_record_tracker tracker = new();
  logic [7:0] sec_q[$];
  int in_idle_pct;
  int out_idle_pct;
  bit long_stall;
  int bytes_sent;
  int idle_cycles;

  eit_section_parser_top #(
    .MAX_SECTION_BYTES(MaxSectionBytes)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte_value(in_byte_value),
    .in_section_start(in_section_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_record_kind(out_record_kind),
    .out_table_ident(out_table_ident),
    .out_length_of_section(out_length_of_section),
    .out_service_ident(out_service_ident),
    .out_version_value(out_version_value),
    .out_indicator_flags(out_indicator_flags),
    .out_section_numbers(out_section_numbers),
    .out_network_idents(out_network_idents),
    .out_segment_info(out_segment_info),
    .out_event_ident(out_event_ident),
    .out_time_or_check(out_time_or_check),
    .out_event_info(out_event_info)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_stall = 0;
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    eit_record_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind = eit_pkg::kind_t'(out_record_kind);
        got.table_ident = out_table_ident;
        got.length_of_section = out_length_of_section;
        got.service_ident = out_service_ident;
        got.version_value = out_version_value;
        got.indicator_flags = out_indicator_flags;
        got.section_numbers = out_section_numbers;
        got.network_idents = out_network_idents;
        got.segment_info = out_segment_info;
        got.event_ident = out_event_ident;
        got.time_or_check = out_time_or_check;
        got.event_info = out_event_info;
        tracker.match_record(got);
      end
      if (in_valid && in_ready) tracker.take_byte(in_byte_value, in_section_start);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_section_start <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_section(input int count);
    for (int i = 0; i < count; i++) send_byte(sec_q[i], i == 0);
    bytes_sent += count;
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), 1'b0);
  endtask

  function automatic void patch_length(input int len);
    logic [11:0] l;
    l = 12'(len);
    sec_q[1] = {sec_q[1][7:4], l[11:8]};
    sec_q[2] = l[7:0];
  endfunction

  function automatic void build_section(input int n_events, input int tail, input bit overrun);
    logic [11:0] desc_len;
    sec_q.delete();
    repeat (14) sec_q.push_back(8'($urandom));
    for (int e = 0; e < n_events + overrun; e++) begin
      desc_len = (overrun && e == n_events) ? 12'($urandom_range(13, 4095)) :
                                              12'($urandom_range(0, 9));
      repeat (10) sec_q.push_back(8'($urandom));
      sec_q.push_back({4'($urandom), desc_len[11:8]});
      sec_q.push_back(desc_len[7:0]);
      repeat ((desc_len > 9) ? $urandom_range(0, 8) : desc_len) sec_q.push_back(8'($urandom));
    end
    repeat (tail + eit_pkg::CrcBytes) sec_q.push_back(8'($urandom));
    patch_length(sec_q.size() - eit_pkg::TotalExtra);
  endfunction

  task automatic run_random(input int goal);
    int pick;
    int tail;
    bytes_sent = 0;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      tail = ($urandom_range(3) == 0) ? $urandom_range(1, 11) : 0;
      if (pick < 60) begin
        build_section($urandom_range(0, 4), tail, 1'b0);
        send_section(sec_q.size());
        if ($urandom_range(4) == 0) send_noise($urandom_range(1, 3));
      end else if (pick < 70) begin
        build_section($urandom_range(0, 3), 0, 1'b1);
        send_section(sec_q.size());
      end else if (pick < 80) begin
        build_section($urandom_range(1, 4), tail, 1'b0);
        send_section($urandom_range(1, sec_q.size() - 1));
      end else if (pick < 86) begin
        build_section(0, 0, 1'b0);
        patch_length($urandom_range(0, eit_pkg::MinTotal - eit_pkg::TotalExtra - 1));
        send_section(sec_q.size());
      end else if (pick < 90) begin
        build_section(0, 0, 1'b0);
        patch_length($urandom_range(MaxSectionBytes - eit_pkg::TotalExtra + 1, 4095));
        send_section(sec_q.size());
      end else if (pick < 94) begin
        build_section(0, 0, 1'b0);
        repeat ($urandom_range(40, 80)) sec_q.push_back(8'($urandom));
        patch_length($urandom_range(1) ? MaxSectionBytes - eit_pkg::TotalExtra :
                     $urandom_range(1000, MaxSectionBytes - eit_pkg::TotalExtra));
        send_section(sec_q.size());
      end else begin
        send_noise($urandom_range(1, 5));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_value = 8'h00;
    in_section_start = 1'b0;
    in_idle_pct = 35;
    out_idle_pct = 50;
    long_stall = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    sec_q = '{8'h4E, 8'hF0, 8'h00};
    patch_length(eit_pkg::MinTotal - eit_pkg::TotalExtra - 1);
    send_section(sec_q.size());
    sec_q.delete();
    repeat (eit_pkg::MinTotal) sec_q.push_back(8'hFF);
    patch_length(eit_pkg::MinTotal - eit_pkg::TotalExtra);
    send_section(sec_q.size());
    sec_q = '{8'hFF, 8'hFF, 8'hFF};
    send_section(sec_q.size());

    run_random(433);
    in_idle_pct = 50;
    out_idle_pct = 35;
    run_random(433);
    in_idle_pct = 0;
    out_idle_pct = 0;
    long_stall = 1;
    run_random(434);

    in_valid <= 1'b0;
    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/eit_pkg.sv
design/eit_section_parser_top.sv
bench/tb_eit_section_parser_top.sv
